// ===== rtl/rc4_pkg.sv =====
`default_nettype none

package rc4_pkg;

  localparam int PERM_DEPTH = 256;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_KEY_END,
    CMD_DATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        rekey;
    logic [7:0]  value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/rc4_front.sv =====
`default_nettype none

module rc4_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // byte_value
  input  wire logic [1:0]    s_tuser,   // req_type, rekey
  input  wire logic          s_tlast,   // key_last
  output logic               push_valid,
  input  wire logic          push_ready,
  output rc4_pkg::cmd_t      push_cmd
);

  logic          vld;
  rc4_pkg::cmd_t cmd;
  rc4_pkg::cmd_t cmd_next;

  always_comb begin
    cmd_next.value = s_tdata;
    cmd_next.rekey = 1'b0;
    if (s_tuser[0]) begin
      cmd_next.kind = rc4_pkg::CMD_DATA;
    end else if (s_tlast) begin
      cmd_next.kind  = rc4_pkg::CMD_KEY_END;
      cmd_next.rekey = s_tuser[1];
    end else begin
      cmd_next.kind = rc4_pkg::CMD_KEY;
    end
  end

  assign s_tready   = !vld || push_ready;
  assign push_valid = vld;
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      vld <= 1'b1;
    end else if (push_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rc4_queue.sv =====
`default_nettype none

module rc4_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire rc4_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output rc4_pkg::cmd_t      pop_cmd
);

  rc4_pkg::cmd_t                 slots [rc4_pkg::Q_DEPTH];
  logic [rc4_pkg::Q_AW-1:0]      wptr;
  logic [rc4_pkg::Q_AW-1:0]      rptr;
  logic [rc4_pkg::Q_CW-1:0]      count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != rc4_pkg::Q_CW'(rc4_pkg::Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rc4_core.sv =====
`default_nettype none

module rc4_core #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire rc4_pkg::cmd_t q_cmd,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata
);

  localparam int KCW = $clog2(MAX_KEY_BYTES + 1);
  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DA,
    ST_DB,
    ST_DT,
    ST_DWAIT,
    ST_KRD,
    ST_KACC,
    ST_KSW1,
    ST_KSW2
  } state_t;

  state_t           state;
  logic [7:0]       i;
  logic [7:0]       j;
  logic [7:0]       a_q;
  logic [7:0]       b_q;
  logic [7:0]       t_q;
  logic [7:0]       val_q;
  logic [7:0]       res_q;
  logic [7:0]       x;
  logic [7:0]       acc;
  logic [7:0]       tmp_q;
  logic             fwd;
  logic [KAW-1:0]   kpos;
  logic [KCW-1:0]   kcnt;

  // permutation store, unwritten entries read as their own index
  logic [7:0]       perm [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::PERM_DEPTH-1:0] pvalid;
  logic [7:0]       rd_q;
  logic             vrd_q;
  logic [7:0]       raddr_q;
  logic [7:0]       raddr;
  logic [7:0]       rdata;
  logic             we;
  logic [7:0]       waddr;
  logic [7:0]       wdata;
  logic             clr;

  logic [7:0]       kstore [MAX_KEY_BYTES];
  logic [7:0]       krd_q;
  logic [KAW-1:0]   kraddr;
  logic             kwe;

  logic             pop;
  logic             out_free;
  logic             out_load;
  logic [7:0]       tmp_v;
  logic [7:0]       acc_n;
  logic [7:0]       ks;
  logic [7:0]       res;
  logic [KCW-1:0]   kpos_inc;

  assign rdata    = vrd_q ? rd_q : raddr_q;
  assign q_ready  = (state == ST_IDLE);
  assign pop      = q_valid && q_ready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == ST_DT) || (state == ST_DWAIT)) && out_free;
  assign tmp_v    = fwd ? tmp_q : rdata;
  assign acc_n    = acc + krd_q + tmp_v;
  assign ks       = (t_q == j) ? a_q : ((t_q == i) ? b_q : rdata);
  assign res      = val_q ^ ks;
  assign kpos_inc = KCW'(kpos) + KCW'(1);
  assign kwe      = pop && (q_cmd.kind != rc4_pkg::CMD_DATA) &&
                    (kcnt < KCW'(MAX_KEY_BYTES));
  assign clr      = pop && (q_cmd.kind == rc4_pkg::CMD_KEY_END) && !q_cmd.rekey;

  always_comb begin
    raddr  = i + 8'd1;
    we     = 1'b0;
    waddr  = x;
    wdata  = rdata;
    kraddr = kpos;
    unique case (state)
      ST_IDLE: begin
        raddr = i + 8'd1;
      end
      ST_DA: begin
        raddr = j + rdata;
      end
      ST_DB: begin
        we    = 1'b1;
        waddr = i;
        wdata = rdata;
        raddr = a_q + rdata;
      end
      ST_DT: begin
        we    = 1'b1;
        waddr = j;
        wdata = a_q;
      end
      ST_DWAIT: begin
        we = 1'b0;
      end
      ST_KRD: begin
        raddr = x;
      end
      ST_KACC: begin
        raddr = acc_n;
      end
      ST_KSW1: begin
        we    = 1'b1;
        waddr = x;
        wdata = rdata;
      end
      ST_KSW2: begin
        we    = 1'b1;
        waddr = acc;
        wdata = tmp_q;
        raddr = x + 8'd1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      perm[waddr] <= wdata;
    end
    rd_q    <= perm[raddr];
    vrd_q   <= pvalid[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      pvalid <= '0;
    end else if (we) begin
      pvalid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      kstore[kcnt[KAW-1:0]] <= q_cmd.value;
    end
    krd_q <= kstore[kraddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      i        <= '0;
      j        <= '0;
      kcnt     <= '0;
      fwd      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (q_cmd.kind == rc4_pkg::CMD_DATA) begin
              i     <= i + 8'd1;
              val_q <= q_cmd.value;
              state <= ST_DA;
            end else begin
              if (kwe) begin
                kcnt <= kcnt + 1'b1;
              end
              if (q_cmd.kind == rc4_pkg::CMD_KEY_END) begin
                if (!q_cmd.rekey) begin
                  i <= '0;
                  j <= '0;
                end
                x     <= '0;
                acc   <= '0;
                kpos  <= '0;
                fwd   <= 1'b0;
                state <= ST_KRD;
              end
            end
          end
        end
        ST_DA: begin
          a_q   <= rdata;
          j     <= j + rdata;
          state <= ST_DB;
        end
        ST_DB: begin
          b_q   <= rdata;
          t_q   <= a_q + rdata;
          state <= ST_DT;
        end
        ST_DT: begin
          if (out_free) begin
            m_tdata  <= res;
            state    <= ST_IDLE;
          end else begin
            res_q <= res;
            state <= ST_DWAIT;
          end
        end
        ST_DWAIT: begin
          if (out_free) begin
            m_tdata  <= res_q;
            state    <= ST_IDLE;
          end
        end
        ST_KRD: begin
          state <= ST_KACC;
        end
        ST_KACC: begin
          acc   <= acc_n;
          tmp_q <= tmp_v;
          if (kpos_inc >= kcnt) begin
            kpos <= '0;
          end else begin
            kpos <= kpos_inc[KAW-1:0];
          end
          state <= ST_KSW1;
        end
        ST_KSW1: begin
          state <= ST_KSW2;
        end
        ST_KSW2: begin
          // next position may be the entry just swapped in
          fwd <= ((x + 8'd1) == acc);
          x   <= x + 8'd1;
          if (x == 8'hFF) begin
            kcnt  <= '0;
            state <= ST_IDLE;
          end else begin
            state <= ST_KACC;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_kcnt_bound: assert property (@(posedge clk) disable iff (rst)
    kcnt <= KCW'(MAX_KEY_BYTES))
    else $error("key count beyond key store");

  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KSW2 && x == 8'hFF) |=> (kcnt == '0 && state == ST_IDLE))
    else $error("key count not cleared after schedule");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DT || state == ST_DWAIT))
    else $error("result loaded outside data step");

  a_fwd_src: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KACC && fwd) |-> $past(state == ST_KSW2))
    else $error("stale swap forwarding");

endmodule

`default_nettype wire

// ===== rtl/rc4_stream_cipher_top.sv =====
// rc4 byte stream cipher
// input channel s_*: one beat per byte. s_tuser[0] selects key byte (0) or
// data byte (1); s_tlast marks the final key byte; s_tuser[1] on that final
// key byte keeps the current permutation and indices instead of restarting
// from the identity. key bytes past MAX_KEY_BYTES are dropped.
// output channel m_*: one beat per data byte, input xor keystream, in order.
// key beats give no output beat.
// beats pass an input register and a four-deep command queue before the
// cipher engine. a key byte is stored in ST_IDLE; the final key byte then
// holds the engine for the key schedule: ST_KRD, then ST_KACC, ST_KSW1 and
// ST_KSW2 for each of the 256 positions, set by the single read and write
// port of the permutation memory. a data byte passes ST_DA, ST_DB and ST_DT
// (three dependent permutation reads and two writes); new commands only in ST_IDLE.
// reset restores the identity permutation at once through per-entry valid
// flags, zero indices and an empty key store; no clearing pass is needed.
// while m_tready is low one result is held and the engine stalls at the next
// data byte; key bytes before it still pass and the queue fills until full.
`default_nettype none

module rc4_stream_cipher_top #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // byte_value
  input  wire logic [1:0]  s_tuser,   // req_type, rekey
  input  wire logic        s_tlast,   // key_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // out_byte
);

  logic          push_valid;
  logic          push_ready;
  rc4_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop_ready;
  rc4_pkg::cmd_t pop_cmd;

  rc4_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  rc4_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  rc4_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_cmd    (pop_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
